// ===== rtl/cbtpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbtpg_pkg
// Shared types, constants and the color palette of the color-bar source.
// ----------------------------------------------------------------------------
package cbtpg_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// configuration port
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(1024);
	localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(768);

	// divider: quotient of 21x/w, always below 21
	localparam int QW        = 5;
	localparam int STEP_W    = 3;
	localparam int DIV_STEPS = QW;

	// palette indexes
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] PAL_WHITE     = IDX_W'(0);
	localparam logic [IDX_W-1:0] PAL_LAST_BAR  = IDX_W'(6);
	localparam logic [IDX_W-1:0] PAL_ACCENT_A  = IDX_W'(7);
	localparam logic [IDX_W-1:0] PAL_ACCENT_B  = IDX_W'(8);
	localparam logic [IDX_W-1:0] PAL_DARK_GRAY = IDX_W'(10);
	localparam logic [IDX_W-1:0] PAL_BLACK     = IDX_W'(11);
	localparam logic [QW-1:0]    RAMP_BASE     = QW'(26);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              adjust;    // latch wrapped counters of a new item
		logic              load;      // load dividend
		logic              div_step;  // one restoring-division step
		logic [STEP_W-1:0] step;      // quotient bit of this step
		logic              finish;    // write output register, advance counters
	} cmd_t;

	// floor(q / 3) for a quotient below 21
	function automatic logic [2:0] div3(input logic [QW-1:0] q);
		logic [2:0] r;
		if (q >= QW'(18))      r = 3'd6;
		else if (q >= QW'(15)) r = 3'd5;
		else if (q >= QW'(12)) r = 3'd4;
		else if (q >= QW'(9))  r = 3'd3;
		else if (q >= QW'(6))  r = 3'd2;
		else if (q >= QW'(3))  r = 3'd1;
		else                   r = 3'd0;
		return r;
	endfunction

	// {byte3, byte2, byte1, byte0}
	function automatic logic [31:0] palette_color(input logic [IDX_W-1:0] idx);
		logic [31:0] c;
		case (idx)
			4'd0:    c = 32'hffff_ffff;
			4'd1:    c = 32'hffff_ff00;
			4'd2:    c = 32'hff00_ffff;
			4'd3:    c = 32'hff00_ff00;
			4'd4:    c = 32'hffff_00ff;
			4'd5:    c = 32'hffff_0000;
			4'd6:    c = 32'hff00_00ff;
			4'd7:    c = 32'hff5f_01ba;
			4'd8:    c = 32'hff00_3d8d;
			4'd9:    c = 32'hff22_2222;
			4'd10:   c = 32'hff10_1010;
			default: c = 32'hff00_0000;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/cbtpg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbtpg_ctrl
// Sequencer: accepts a tick, runs the divider, hands the pixel to the output
// register and tracks output valid.
// ----------------------------------------------------------------------------
module cbtpg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output cbtpg_pkg::cmd_t  cmd
);
	import cbtpg_pkg::*;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.adjust = 1'b1;
					state_d    = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				step_d   = STEP_W'(DIV_STEPS - 1);
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.step     = step_q;
				if (step_q == '0) begin
					state_d = S_DONE;
				end else begin
					step_d = step_q - STEP_W'(1);
				end
			end
			S_DONE: begin
				// wait until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cmd.finish) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/cbtpg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbtpg_datapath
// Size registers, raster counters, restoring divider for 21x/w, palette
// index selection and the output register.
// ----------------------------------------------------------------------------
module cbtpg_datapath #(
	parameter int MAX_WIDTH  = cbtpg_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cbtpg_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cbtpg_pkg::cmd_t                 cmd,
	input  logic                            restart,
	input  logic                            cfg_wr,
	input  logic [cbtpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbtpg_pkg::CFG_W-1:0]     cfg_data,
	output logic [7:0]                      pixel_byte0,
	output logic [7:0]                      pixel_byte1,
	output logic [7:0]                      pixel_byte2,
	output logic [7:0]                      pixel_byte3,
	output logic                            end_of_line,
	output logic                            end_of_frame
);
	import cbtpg_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);
	localparam int LW = CFG_W + 1;
	localparam int DW = XW + 5;   // holds 28x and w << 4
	localparam int YP = YW + 2;   // holds 4y and 3h

	logic [CFG_W-1:0] frame_width_q, frame_height_q;
	logic [XW-1:0]    w_c, x_q, x_adj;
	logic [YW-1:0]    h_c, y_q, y_adj, y_mid;
	logic [DW-1:0]    rem_q, div_shift;
	logic [QW-1:0]    quo_q;
	logic [QW-1:0]    ramp;
	logic [2:0]       seg;
	logic [IDX_W-1:0] idx;
	logic [DW-1:0]    x28, w_one;
	logic             top_band, mid_band, eol, eof;
	logic [31:0]      color;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero counts as one, oversize clamps to the maximum
	always_comb begin
		if (frame_width_q == '0) begin
			w_c = XW'(1);
		end else if ({1'b0, frame_width_q} > LW'(MAX_WIDTH)) begin
			w_c = XW'(MAX_WIDTH);
		end else begin
			w_c = XW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_c = YW'(1);
		end else if ({1'b0, frame_height_q} > LW'(MAX_HEIGHT)) begin
			h_c = YW'(MAX_HEIGHT);
		end else begin
			h_c = YW'(frame_height_q);
		end
	end

	// restart, then wrap counters left beyond a lowered size
	always_comb begin
		x_adj = restart ? '0 : x_q;
		y_mid = restart ? '0 : y_q;
		if (x_adj >= w_c) begin
			x_adj = '0;
			y_mid = y_mid + YW'(1);
		end
		y_adj = (y_mid >= h_c) ? '0 : y_mid;
	end

	assign eol = (x_q == w_c - XW'(1));
	assign eof = eol && (y_q == h_c - YW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
		end else if (cmd.adjust) begin
			x_q <= x_adj;
			y_q <= y_adj;
		end else if (cmd.finish) begin
			if (eol) begin
				x_q <= '0;
				y_q <= eof ? '0 : y_q + YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	// restoring divider, one quotient bit per cycle, MSB first
	assign div_shift = DW'(w_c) << cmd.step;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= DW'(x_q) * DW'(21);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= div_shift) begin
				rem_q            <= rem_q - div_shift;
				quo_q[cmd.step]  <= 1'b1;
			end
		end
	end

	// palette index; 7x/w is floor of (21x/w)/3
	assign seg      = div3(quo_q);
	assign top_band = (YP'(y_q) * YP'(3)) < (YP'(h_c) * YP'(2));
	assign mid_band = (YP'(y_q) * YP'(4)) < (YP'(h_c) * YP'(3));
	assign x28      = DW'(x_q) * DW'(28);
	assign w_one    = DW'(w_c);
	assign ramp     = RAMP_BASE - quo_q;

	always_comb begin
		if (top_band) begin
			idx = IDX_W'(seg);
		end else if (mid_band) begin
			idx = seg[0] ? PAL_DARK_GRAY : PAL_LAST_BAR - IDX_W'(seg);
		end else if (x28 < w_one * DW'(5)) begin
			idx = PAL_ACCENT_B;
		end else if (x28 < w_one * DW'(10)) begin
			idx = PAL_WHITE;
		end else if (x28 < w_one * DW'(15)) begin
			idx = PAL_ACCENT_A;
		end else if (x28 < w_one * DW'(20)) begin
			idx = PAL_DARK_GRAY;
		end else if (x28 < w_one * DW'(24)) begin
			// gray ramp
			idx = (ramp > QW'(PAL_BLACK)) ? PAL_BLACK : IDX_W'(ramp);
		end else begin
			idx = PAL_DARK_GRAY;
		end
	end

	assign color = palette_color(idx);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pixel_byte0  <= color[7:0];
			pixel_byte1  <= color[15:8];
			pixel_byte2  <= color[23:16];
			pixel_byte3  <= color[31:24];
			end_of_line  <= eol;
			end_of_frame <= eof;
		end
	end

endmodule

// ===== rtl/color_bar_test_pattern_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_bar_test_pattern_generator_core
// Color-bar test card source: one pixel with line and frame marks per tick.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid / in_ready    | restart
//  out      | out_valid / out_ready  | pixel_byte0..3, end_of_line, end_of_frame
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A pixel passes through accept, dividend load, five restoring-division
// steps for 21x/w and output write, in that order. The output write sets
// the result valid; the next tick is taken after it, once back in idle.
// Reset clears the counters to pixel (0,0) and sets a 1024 x 768 frame.
// The next tick is taken while a result waits; a stalled output holds the
// following pixel in its last cycle until the output register frees up.
// cfg is always ready.
module color_bar_test_pattern_generator_core #(
	parameter int MAX_WIDTH  = cbtpg_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = cbtpg_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      pixel_byte0,
	output logic [7:0]                      pixel_byte1,
	output logic [7:0]                      pixel_byte2,
	output logic [7:0]                      pixel_byte3,
	output logic                            end_of_line,
	output logic                            end_of_frame,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbtpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbtpg_pkg::CFG_W-1:0]     cfg_data
);
	import cbtpg_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	cbtpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	cbtpg_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.restart      (restart),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_byte0  (pixel_byte0),
		.pixel_byte1  (pixel_byte1),
		.pixel_byte2  (pixel_byte2),
		.pixel_byte3  (pixel_byte3),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the color-bar test card source. Every pixel tick
// that is transferred in is run through a predictor of the raster counters and
// the band/segment palette choice. Each pixel transferred out is compared field
// by field against the oldest prediction. Frame sizes are changed while the
// pipe is empty, and include the clamped, ignored and minimum cases.
// ----------------------------------------------------------------------------
module tb;
	import cbtpg_pkg::*;

	// writes to these indexes must be dropped by the block
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	// {byte0, byte1, byte2} of each palette entry, entry 0 first
	localparam logic [0:11][23:0] SWATCH = {
		24'hffffff, 24'h00ffff, 24'hffff00, 24'h00ff00,
		24'hff00ff, 24'h0000ff, 24'hff0000, 24'hba015f,
		24'h8d3d00, 24'h222222, 24'h101010, 24'h000000
	};

	typedef struct {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic       eol;
		logic       eof;
	} pixel_t;

	class test_card_checker;
		int unsigned width_reg;
		int unsigned height_reg;
		int unsigned col;
		int unsigned row;
		int unsigned errors;
		pixel_t      expected_pixels[$];

		function new();
			width_reg  = 32'(RST_FRAME_WIDTH);
			height_reg = 32'(RST_FRAME_HEIGHT);
			col        = 0;
			row        = 0;
			errors     = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_FRAME_WIDTH)
				width_reg = 32'(val);
			else if (idx == REG_FRAME_HEIGHT)
				height_reg = 32'(val);
		endfunction

		function int unsigned pending();
			return expected_pixels.size();
		endfunction

		function void note_tick(bit rs);
			int unsigned w;
			int unsigned h;
			int unsigned seg;
			int unsigned k;
			pixel_t      p;
			w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
			h = (height_reg == 0) ? 1 : (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
			if (rs) begin
				col = 0;
				row = 0;
			end
			// size lowered mid-frame: fold stale counters back in
			if (col >= w) begin
				col = 0;
				row++;
			end
			if (row >= h)
				row = 0;

			if (3 * row < 2 * h) begin
				k = (7 * col) / w;
			end else if (4 * row < 3 * h) begin
				seg = (7 * col) / w;
				k = seg[0] ? 32'(PAL_DARK_GRAY) : 32'(PAL_LAST_BAR) - seg;
			end else if (28 * col < 5 * w) begin
				k = 32'(PAL_ACCENT_B);
			end else if (28 * col < 10 * w) begin
				k = 32'(PAL_WHITE);
			end else if (28 * col < 15 * w) begin
				k = 32'(PAL_ACCENT_A);
			end else if (28 * col < 20 * w) begin
				k = 32'(PAL_DARK_GRAY);
			end else if (7 * col < 6 * w) begin
				k = 32'(RAMP_BASE) - (21 * col) / w;
			end else begin
				k = 32'(PAL_DARK_GRAY);
			end
			if (k > 32'(PAL_BLACK))
				k = 32'(PAL_BLACK);

			p.b0  = SWATCH[k[3:0]][23:16];
			p.b1  = SWATCH[k[3:0]][15:8];
			p.b2  = SWATCH[k[3:0]][7:0];
			p.b3  = 8'hff;
			p.eol = (col == w - 1);
			p.eof = p.eol && (row == h - 1);
			expected_pixels.push_back(p);

			if (p.eol) begin
				col = 0;
				row = p.eof ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		function void compare_field(string label, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
				logic [7:0] b3, logic eol, logic eof);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel %h %h %h %h eol %b eof %b",
					$time, b0, b1, b2, b3, eol, eof);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				compare_field("pixel_byte0", 32'(want.b0), 32'(b0));
				compare_field("pixel_byte1", 32'(want.b1), 32'(b1));
				compare_field("pixel_byte2", 32'(want.b2), 32'(b2));
				compare_field("pixel_byte3", 32'(want.b3), 32'(b3));
				compare_field("end_of_line", 32'(want.eol), 32'(eol));
				compare_field("end_of_frame", 32'(want.eof), 32'(eof));
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 restart;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           pixel_byte0;
	logic [7:0]           pixel_byte1;
	logic [7:0]           pixel_byte2;
	logic [7:0]           pixel_byte3;
	logic                 end_of_line;
	logic                 end_of_frame;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	test_card_checker card;
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;
	bit               hold_req;
	bit               hold_done;
	int unsigned      hold_left;

	color_bar_test_pattern_generator_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_byte0  (pixel_byte0),
		.pixel_byte1  (pixel_byte1),
		.pixel_byte2  (pixel_byte2),
		.pixel_byte3  (pixel_byte3),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// output side: random back-pressure, plus one long hold-off on request
	initial begin
		hold_left = 0;
		hold_done = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 400;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			card.check_pixel(pixel_byte0, pixel_byte1, pixel_byte2, pixel_byte3,
				end_of_line, end_of_frame);
	end

	// valid stays up across back-to-back ticks; it drops only for a gap
	task automatic send_pixel(input bit rs);
		int unsigned gap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rs;
		do @(posedge clk); while (!in_ready);
		card.note_tick(rs);
	endtask

	task automatic wait_all_pixels();
		in_valid <= 1'b0;
		while (card.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		card.set_reg(idx, val);
	endtask

	initial begin
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		card          = new();
		send_idle_pct = 17;
		recv_idle_pct = 59;
		hold_req      = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		restart   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset frame size, then a full 6 x 4 card over the top and bottom bands
		send_pixel(1'b1);
		send_pixel(1'b0);
		wait_all_pixels();
		write_reg(REG_FRAME_WIDTH, CFG_W'(6));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(4));
		for (int n = 0; n < 24; n++)
			send_pixel(n == 0);

		for (int ph = 0; ph < 12; ph++) begin
			case (ph / 4)
				0: begin
					send_idle_pct = 17;
					recv_idle_pct = 59;
				end
				1: begin
					send_idle_pct = 59;
					recv_idle_pct = 17;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			wait_all_pixels();
			case (ph)
				0: begin
					w = CFG_W'(1);
					h = CFG_W'(1);
				end
				1: begin
					w = CFG_W'(0);
					h = CFG_W'(0);
				end
				3: begin
					w = CFG_W'(8191);
					h = CFG_W'(8191);
				end
				4: begin
					w = CFG_W'(4096);
					h = CFG_W'(4096);
				end
				5: begin
					w = CFG_W'($urandom_range(4097, 8191));
					h = CFG_W'($urandom_range(1, 4));
				end
				6: begin
					w = CFG_W'(37);
					h = CFG_W'(4);
				end
				default: begin
					w = CFG_W'($urandom_range(1, 24));
					h = CFG_W'($urandom_range(1, 12));
				end
			endcase
			write_reg(REG_FRAME_WIDTH, w);
			// width-only change can leave the counters past the new edge
			if (ph != 9)
				write_reg(REG_FRAME_HEIGHT, h);
			if (ph % 4 == 2)
				write_reg((ph == 2) ? REG_SPARE_LO : REG_SPARE_HI,
					CFG_W'($urandom_range(0, 8191)));
			for (int n = 0; n < 150; n++) begin
				if (ph == 2 && n == 40)
					hold_req = 1'b1;
				send_pixel($urandom_range(0, 29) == 0);
			end
		end

		wait_all_pixels();
		repeat (40) @(posedge clk);
		if (card.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
